[sv/scp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scp_pkg;

    // Fixed widths of the configuration registers, the configuration port and the pixel word.
    localparam int VIEW_MIN_W = 32;
    localparam int SPAN_W     = 32;
    localparam int STRIPE_W   = 11;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PIXEL_W    = 32;

    localparam logic [SPAN_W-1:0]   VIEW_SPAN_RST = 32'h0001_0000;
    localparam logic [STRIPE_W-1:0] STRIPES_RST   = 11'd1;

    localparam logic [23:0] RAMP24_MAX = 24'hFF_FFFF;
    localparam logic [15:0] RAMP16_MAX = 16'hFFFF;
    localparam logic [7:0]  CHAN_MAX   = 8'hFF;
    localparam logic [7:0]  ALPHA      = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIEW_MIN  = 2'd0,
        REG_VIEW_SPAN = 2'd1,
        REG_STRIPES   = 2'd2,
        REG_MODE      = 2'd3
    } t_cfg_index;

    typedef enum logic [MODE_W-1:0] {
        MODE_RAMP24  = 3'd0,
        MODE_RAMP16  = 3'd1,
        MODE_RAINBOW = 3'd2,
        MODE_GREY    = 3'd3,
        MODE_BINARY  = 3'd4
    } t_color_mode;

    // Side-band flags that ride along with a sample through the dividers.
    typedef struct packed {
        logic full;   // offset reached the span, level is 1.0
        logic neg;    // scaled offset was negative
    } t_flags;

endpackage

`default_nettype wire

[sv/scp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module scp_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_en,
    input  wire                                      i_valid,
    input  wire  signed [SAMPLE_WIDTH-1:0]           i_sample,
    input  wire  signed [scp_pkg::VIEW_MIN_W-1:0]    i_view_min,
    input  wire         [scp_pkg::SPAN_W-1:0]        i_span,
    input  wire         [scp_pkg::STRIPE_W-1:0]      i_stripes,
    output logic                                     o_valid,
    output scp_pkg::t_flags                          o_flags,
    output logic [((SAMPLE_WIDTH > scp_pkg::VIEW_MIN_W) ? SAMPLE_WIDTH : scp_pkg::VIEW_MIN_W)
                  + scp_pkg::STRIPE_W:0]             o_mag
);

    localparam int OFF_W  = ((SAMPLE_WIDTH > scp_pkg::VIEW_MIN_W) ?
                             SAMPLE_WIDTH : scp_pkg::VIEW_MIN_W) + 1;
    localparam int PROD_W = OFF_W + scp_pkg::STRIPE_W + 1;
    localparam int MAG_W  = PROD_W - 1;

    logic signed [OFF_W-1:0]           n_off;
    logic                              n_full;
    logic signed [scp_pkg::STRIPE_W:0] w_stripes;
    logic signed [PROD_W-1:0]          n_prod;
    logic        [MAG_W-1:0]           n_mag;

    logic                     r_valid1, r_valid2, r_valid3;
    logic signed [OFF_W-1:0]  r_off;
    logic                     r_full1, r_full2;
    logic signed [PROD_W-1:0] r_prod;
    scp_pkg::t_flags          r_flags;
    logic [MAG_W-1:0]         r_mag;

    // Offset is exact: both operands are sign extended one bit past the wider one.
    assign n_off  = OFF_W'(i_sample) - OFF_W'(i_view_min);
    assign n_full = n_off >= $signed(OFF_W'({1'b0, i_span}));

    assign w_stripes = $signed({1'b0, i_stripes});
    assign n_prod    = PROD_W'(r_off) * PROD_W'(w_stripes);

    assign n_mag = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
            r_valid3 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
            r_valid3 <= r_valid2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_off         <= n_off;
            r_full1       <= n_full;
            r_prod        <= n_prod;
            r_full2       <= r_full1;
            r_mag         <= n_mag;
            r_flags.full  <= r_full2;
            r_flags.neg   <= r_prod[PROD_W-1];
        end
    end

    assign o_valid = r_valid3;
    assign o_flags = r_flags;
    assign o_mag   = r_mag;

endmodule

`default_nettype wire

[sv/scp_div_pipe.sv]
`timescale 1ns / 1ps
`default_nettype none

// Restoring long division, one dividend bit per register stage. The partial
// remainder starts at i_rem and must be below i_span; the quotient bits shift
// into the dividend word as its bits are consumed.
module scp_div_pipe #(
    parameter int N_BITS = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire                           i_valid,
    input  wire  scp_pkg::t_flags         i_flags,
    input  wire  [scp_pkg::SPAN_W-1:0]    i_rem,
    input  wire  [N_BITS-1:0]             i_bits,
    input  wire  [scp_pkg::SPAN_W-1:0]    i_span,
    output logic                          o_valid,
    output scp_pkg::t_flags               o_flags,
    output logic [scp_pkg::SPAN_W-1:0]    o_rem,
    output logic [N_BITS-1:0]             o_quot
);

    localparam int SW = scp_pkg::SPAN_W;

    logic            w_valid [N_BITS];
    scp_pkg::t_flags w_flags [N_BITS];
    logic [SW-1:0]   w_rem   [N_BITS];
    logic [N_BITS-1:0] w_bits [N_BITS];

    logic            r_valid [N_BITS];
    scp_pkg::t_flags r_flags [N_BITS];
    logic [SW-1:0]   r_rem   [N_BITS];
    logic [N_BITS-1:0] r_bits [N_BITS];

    for (genvar k = 0; k < N_BITS; k++) begin : g_stage
        logic [SW:0]       n_trial;
        logic              n_ge;
        logic [SW-1:0]     n_rem;
        logic [N_BITS-1:0] n_bits;

        if (k == 0) begin : g_first
            assign w_valid[k] = i_valid;
            assign w_flags[k] = i_flags;
            assign w_rem[k]   = i_rem;
            assign w_bits[k]  = i_bits;
        end else begin : g_next
            assign w_valid[k] = r_valid[k-1];
            assign w_flags[k] = r_flags[k-1];
            assign w_rem[k]   = r_rem[k-1];
            assign w_bits[k]  = r_bits[k-1];
        end

        assign n_trial = {w_rem[k], w_bits[k][N_BITS-1]};
        assign n_ge    = n_trial >= {1'b0, i_span};
        assign n_rem   = n_ge ? SW'(n_trial - {1'b0, i_span}) : SW'(n_trial);
        assign n_bits  = N_BITS'({w_bits[k], n_ge});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_flags[k] <= w_flags[k];
                r_rem[k]   <= n_rem;
                r_bits[k]  <= n_bits;
            end
        end
    end

    assign o_valid = r_valid[N_BITS-1];
    assign o_flags = r_flags[N_BITS-1];
    assign o_rem   = r_rem[N_BITS-1];
    assign o_quot  = r_bits[N_BITS-1];

endmodule

`default_nettype wire

[sv/scp_colorize.sv]
`timescale 1ns / 1ps
`default_nettype none

module scp_colorize #(
    parameter int FRAC_BITS = 16
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  wire                               i_valid,
    input  wire                               i_full,
    input  wire  [FRAC_BITS-1:0]              i_quot,
    input  wire  [scp_pkg::MODE_W-1:0]        i_mode,
    output logic                              o_valid,
    output logic [scp_pkg::PIXEL_W-1:0]       o_word
);

    localparam int LVL_W = FRAC_BITS + 1;
    localparam int A_W   = FRAC_BITS + 3;
    localparam logic [LVL_W-1:0] ONE  = LVL_W'(1) << FRAC_BITS;
    localparam logic [LVL_W-1:0] HALF = LVL_W'(1) << (FRAC_BITS - 1);

    // Rainbow bands, from red at level 1.0 down to magenta at level 0.
    localparam logic [2:0] BAND_RED_YELLOW  = 3'd0;
    localparam logic [2:0] BAND_YELLOW_GRN  = 3'd1;
    localparam logic [2:0] BAND_GRN_CYAN    = 3'd2;
    localparam logic [2:0] BAND_CYAN_BLUE   = 3'd3;
    localparam logic [2:0] BAND_BLUE_MAG    = 3'd4;

    logic [LVL_W-1:0]    w_level;
    logic [24+LVL_W-1:0] w_p24;
    logic [16+LVL_W-1:0] w_p16;
    logic [8+LVL_W-1:0]  w_p8;
    logic [7:0]          w_grey;
    logic [23:0]         n_rgb;
    logic [A_W-1:0]      n_a;

    logic [2:0]            w_band;
    logic [FRAC_BITS+7:0]  w_py;
    logic [7:0]            w_y;
    logic [23:0]           w_rainbow;
    logic [23:0]           w_rgb_out;

    logic                  r_valid1, r_valid2;
    logic [23:0]           r_rgb;
    logic                  r_rainbow;
    logic [A_W-1:0]        r_a;
    logic [scp_pkg::PIXEL_W-1:0] r_word;

    assign w_level = i_full ? ONE : {1'b0, i_quot};
    assign w_p24   = (24+LVL_W)'(w_level) * (24+LVL_W)'(scp_pkg::RAMP24_MAX);
    assign w_p16   = (16+LVL_W)'(w_level) * (16+LVL_W)'(scp_pkg::RAMP16_MAX);
    assign w_p8    = (8+LVL_W)'(w_level) * (8+LVL_W)'(scp_pkg::CHAN_MAX);
    assign w_grey  = 8'(w_p8 >> FRAC_BITS);
    assign n_a     = A_W'(3'd5) * A_W'(ONE - w_level);

    always_comb begin
        case (i_mode)
            scp_pkg::MODE_RAMP24: n_rgb = 24'(w_p24 >> FRAC_BITS);
            scp_pkg::MODE_RAMP16: n_rgb = {8'h00, 16'(w_p16 >> FRAC_BITS)};
            scp_pkg::MODE_GREY:   n_rgb = {w_grey, w_grey, w_grey};
            scp_pkg::MODE_BINARY: n_rgb = (w_level >= HALF) ? 24'hFF_FFFF : 24'h00_0000;
            default:              n_rgb = 24'h00_0000;
        endcase
    end

    // Second stage: position within the rainbow band.
    assign w_band = r_a[A_W-1:FRAC_BITS];
    assign w_py   = (FRAC_BITS+8)'(r_a[FRAC_BITS-1:0]) * (FRAC_BITS+8)'(scp_pkg::CHAN_MAX);
    assign w_y    = 8'(w_py >> FRAC_BITS);

    always_comb begin
        case (w_band)
            BAND_RED_YELLOW: w_rainbow = {8'h00, w_y, scp_pkg::CHAN_MAX};
            BAND_YELLOW_GRN: w_rainbow = {8'h00, scp_pkg::CHAN_MAX, scp_pkg::CHAN_MAX - w_y};
            BAND_GRN_CYAN:   w_rainbow = {w_y, scp_pkg::CHAN_MAX, 8'h00};
            BAND_CYAN_BLUE:  w_rainbow = {scp_pkg::CHAN_MAX, scp_pkg::CHAN_MAX - w_y, 8'h00};
            BAND_BLUE_MAG:   w_rainbow = {scp_pkg::CHAN_MAX, 8'h00, w_y};
            default:         w_rainbow = {scp_pkg::CHAN_MAX, 8'h00, scp_pkg::CHAN_MAX};
        endcase
    end

    assign w_rgb_out = r_rainbow ? w_rainbow : r_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else if (i_en) begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rgb     <= n_rgb;
            r_rainbow <= (i_mode == scp_pkg::MODE_RAINBOW);
            r_a       <= n_a;
            r_word    <= {scp_pkg::ALPHA, w_rgb_out};
        end
    end

    assign o_valid = r_valid2;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[sv/scalar_to_color_pixel.sv]
`timescale 1ns / 1ps
`default_nettype none

// Maps each signed fixed-point sample to a packed RGBA pixel through a striped
// color map (ramp24, ramp16, rainbow, grey or binary; alpha is always 0xFF).
// The block takes one sample per clock unless the output beat is held, and
// returns one pixel per sample, in order. Each sample passes the front end,
// the modulo divider, the floor-modulo fix register, the level-fraction
// divider and the colorizer; the two restoring dividers (the modulo by the
// span and the level fraction) retire one quotient bit per pipeline stage.
// The whole pipeline freezes while the output beat is held by i_pixel_stall,
// so o_sample_stall follows it. Configuration writes are always taken and
// must only be made while no beat is in flight.
module scalar_to_color_pixel #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int FRAC_BITS    = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_sample_valid,
    output logic                                o_sample_stall,
    input  wire  signed [SAMPLE_WIDTH-1:0]      i_sample_value,
    output logic                                o_pixel_valid,
    input  wire                                 i_pixel_stall,
    output logic [scp_pkg::PIXEL_W-1:0]         o_pixel_word,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [scp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [scp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int SW    = scp_pkg::SPAN_W;
    localparam int OFF_W = ((SAMPLE_WIDTH > scp_pkg::VIEW_MIN_W) ?
                            SAMPLE_WIDTH : scp_pkg::VIEW_MIN_W) + 1;
    localparam int MAG_W = OFF_W + scp_pkg::STRIPE_W;
    localparam logic [SW-1:0] SPAN_ONE = SW'(1) << FRAC_BITS;

    logic signed [scp_pkg::VIEW_MIN_W-1:0] r_view_min;
    logic [SW-1:0]                r_view_span;
    logic [scp_pkg::STRIPE_W-1:0] r_stripes;
    logic [scp_pkg::MODE_W-1:0]   r_mode;

    logic [SW-1:0]                w_span;
    logic [scp_pkg::STRIPE_W-1:0] w_stripes;
    logic                         w_en;

    logic             f_valid;
    scp_pkg::t_flags  f_flags;
    logic [MAG_W-1:0] f_mag;

    logic             m_valid;
    scp_pkg::t_flags  m_flags;
    logic [SW-1:0]    m_rem;

    logic             n_fix_neg;
    logic [SW-1:0]    n_fix_rem;
    logic             r_fix_valid;
    scp_pkg::t_flags  r_fix_flags;
    logic [SW-1:0]    r_fix_rem;

    logic                 q_valid;
    scp_pkg::t_flags      q_flags;
    logic [FRAC_BITS-1:0] q_quot;

    // Zero span means 1.0 and zero stripes means one stripe.
    assign w_span    = (r_view_span == '0) ? SPAN_ONE : r_view_span;
    assign w_stripes = (r_stripes == '0) ? scp_pkg::STRIPE_W'(1) : r_stripes;

    assign w_en           = !(o_pixel_valid && i_pixel_stall);
    assign o_sample_stall = !w_en;
    assign o_cfg_ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_min  <= '0;
            r_view_span <= scp_pkg::VIEW_SPAN_RST;
            r_stripes   <= scp_pkg::STRIPES_RST;
            r_mode      <= scp_pkg::MODE_RAMP24;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                scp_pkg::REG_VIEW_MIN:  r_view_min  <= $signed(i_cfg_data);
                scp_pkg::REG_VIEW_SPAN: r_view_span <= i_cfg_data;
                scp_pkg::REG_STRIPES:   r_stripes   <= i_cfg_data[scp_pkg::STRIPE_W-1:0];
                scp_pkg::REG_MODE:      r_mode      <= i_cfg_data[scp_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    scp_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_sample_valid),
        .i_sample   (i_sample_value),
        .i_view_min (r_view_min),
        .i_span     (w_span),
        .i_stripes  (w_stripes),
        .o_valid    (f_valid),
        .o_flags    (f_flags),
        .o_mag      (f_mag)
    );

    // Remainder of the scaled offset magnitude by the span.
    scp_div_pipe #(
        .N_BITS (MAG_W)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_flags (f_flags),
        .i_rem   ('0),
        .i_bits  (f_mag),
        .i_span  (w_span),
        .o_valid (m_valid),
        .o_flags (m_flags),
        .o_rem   (m_rem),
        .o_quot  ()
    );

    // Floor modulo: a negative dividend with a nonzero remainder wraps upward.
    assign n_fix_neg = m_flags.neg && (m_rem != '0);
    assign n_fix_rem = n_fix_neg ? (w_span - m_rem) : m_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fix_valid <= 1'b0;
        end else if (w_en) begin
            r_fix_valid <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fix_flags <= m_flags;
            r_fix_rem   <= n_fix_rem;
        end
    end

    // Level fraction: remainder * 2^FRAC_BITS / span.
    scp_div_pipe #(
        .N_BITS (FRAC_BITS)
    ) u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_fix_valid),
        .i_flags (r_fix_flags),
        .i_rem   (r_fix_rem),
        .i_bits  ('0),
        .i_span  (w_span),
        .o_valid (q_valid),
        .o_flags (q_flags),
        .o_rem   (),
        .o_quot  (q_quot)
    );

    scp_colorize #(
        .FRAC_BITS (FRAC_BITS)
    ) u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (q_valid),
        .i_full  (q_flags.full),
        .i_quot  (q_quot),
        .i_mode  (r_mode),
        .o_valid (o_pixel_valid),
        .o_word  (o_pixel_word)
    );

    a_alpha_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel_valid |-> (o_pixel_word[31:24] == scp_pkg::ALPHA))
        else $error("pixel alpha byte is not opaque");

    a_freeze_keeps_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && i_pixel_stall) |=> o_pixel_valid)
        else $error("held output beat was dropped by the pipeline");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_pixel_valid && !r_fix_valid))
        else $error("pipeline holds a beat after reset");

endmodule

`default_nettype wire

[tb/tb_scalar_to_color_pixel.sv]
`timescale 1ns / 1ps

module tb_scalar_to_color_pixel;
    import scp_pkg::*;

    localparam int     LVL_FRAC        = 16;
    localparam longint LVL_ONE         = 64'sd1 << LVL_FRAC;
    localparam int     PIPE_LATENCY    = 66;
    localparam int     QUIET_LIMIT     = 5000;
    localparam int     ITEMS_PER_PHASE = 460;
    localparam int     ITEMS_PER_VIEW  = 46;
    localparam int     REPORT_MAX      = 10;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_sample_valid = 1'b0;
    logic signed [31:0]    i_sample_value = '0;
    logic                  i_pixel_stall  = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = REG_VIEW_MIN;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    wire                   o_sample_stall;
    wire                   o_pixel_valid;
    wire                   o_cfg_ready;
    wire  [PIXEL_W-1:0]    o_pixel_word;

    // Local copy of the view registers, updated as each write beat is taken.
    logic signed [31:0]    view_min_q  = 32'sd0;
    logic [SPAN_W-1:0]     view_span_q = VIEW_SPAN_RST;
    logic [STRIPE_W-1:0]   stripes_q   = STRIPES_RST;
    logic [MODE_W-1:0]     mode_q      = MODE_RAMP24;

    logic [PIXEL_W-1:0]    pending_pixels[$];
    int                    send_idle_pct  = 0;
    int                    stall_pct      = 0;
    int                    mismatch_count = 0;
    int                    quiet_cycles   = 0;

    scalar_to_color_pixel u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_stall (o_sample_stall),
        .i_sample_value (i_sample_value),
        .o_pixel_valid  (o_pixel_valid),
        .i_pixel_stall  (i_pixel_stall),
        .o_pixel_word   (o_pixel_word),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_pixel_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [PIXEL_W-1:0] pixel_of(input logic signed [31:0] sample);
        longint     span_v;
        longint     strp;
        longint     offset;
        longint     rem;
        longint     lvl;
        longint     shade;
        longint     band;
        longint     frac_y;
        logic [7:0] y;
        logic [7:0] grey;
        logic [23:0] rgb;
        span_v = (view_span_q == '0) ? LVL_ONE : longint'(view_span_q);
        strp   = (stripes_q == '0) ? 1 : longint'(stripes_q);
        offset = longint'(sample) - longint'(view_min_q);
        if (offset >= span_v) begin
            lvl = LVL_ONE;
        end else begin
            // Floor modulo, so offsets below the window wrap back into it.
            rem = (offset * strp) % span_v;
            if (rem < 0) rem = rem + span_v;
            lvl = (rem << LVL_FRAC) / span_v;
        end
        case (mode_q)
            MODE_RAMP24: rgb = 24'((longint'(RAMP24_MAX) * lvl) >> LVL_FRAC);
            MODE_RAMP16: rgb = 24'((longint'(RAMP16_MAX) * lvl) >> LVL_FRAC);
            MODE_RAINBOW: begin
                shade  = 5 * (LVL_ONE - lvl);
                band   = shade >> LVL_FRAC;
                frac_y = (longint'(CHAN_MAX) * (shade & (LVL_ONE - 1))) >> LVL_FRAC;
                y      = frac_y[7:0];
                case (band)
                    0:       rgb = {8'h00, y, CHAN_MAX};
                    1:       rgb = {8'h00, CHAN_MAX, CHAN_MAX - y};
                    2:       rgb = {y, CHAN_MAX, 8'h00};
                    3:       rgb = {CHAN_MAX, CHAN_MAX - y, 8'h00};
                    4:       rgb = {CHAN_MAX, 8'h00, y};
                    default: rgb = {CHAN_MAX, 8'h00, CHAN_MAX};
                endcase
            end
            MODE_GREY: begin
                grey = 8'((longint'(CHAN_MAX) * lvl) >> LVL_FRAC);
                rgb  = {3{grey}};
            end
            MODE_BINARY: begin
                grey = (lvl >= LVL_ONE / 2) ? CHAN_MAX : 8'h00;
                rgb  = {3{grey}};
            end
            default: rgb = '0;
        endcase
        return {ALPHA, rgb};
    endfunction

    // Mostly samples near the current window, so that the wrap, the top edge and
    // the stripe fraction all get exercised.
    function automatic logic [31:0] pick_sample();
        logic [31:0] span_v;
        span_v = (view_span_q == '0) ? 32'(LVL_ONE) : view_span_q;
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return view_min_q;
            2:       return view_min_q + span_v;
            3:       return view_min_q + span_v - 1;
            4:       return view_min_q - ($urandom % span_v);
            default: return view_min_q + ($urandom % span_v);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [PIXEL_W-1:0] want,
                                 input logic [PIXEL_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t: pixel %s: expected %h, got %h", $time, what, want, got);
    endtask

    task automatic send_sample(input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_sample_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_sample_valid <= 1'b1;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_sample_stall !== 1'b0);
        pending_pixels.push_back(pixel_of(value));
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_VIEW_MIN:  view_min_q  = data;
            REG_VIEW_SPAN: view_span_q = data;
            REG_STRIPES:   stripes_q   = data[STRIPE_W-1:0];
            REG_MODE:      mode_q      = data[MODE_W-1:0];
        endcase
    endtask

    task automatic wait_idle();
        i_sample_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_view(input logic [31:0] vmin, input logic [31:0] span,
                            input logic [31:0] stripes, input logic [31:0] mode);
        wait_idle();
        write_reg(REG_VIEW_MIN, vmin);
        write_reg(REG_VIEW_SPAN, span);
        write_reg(REG_STRIPES, stripes);
        write_reg(REG_MODE, mode);
        i_cfg_valid <= 1'b0;
    endtask

    // Runs on the register values left by reset.
    task automatic test_reset_extremes();
        logic [31:0] points[$];
        points = '{32'h0000_0000, 32'h0000_0001, 32'h0000_8000, 32'h0000_FFFF,
                   32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                   32'hFFFF_8000};
        foreach (points[i]) send_sample(points[i]);
    endtask

    task automatic test_color_modes();
        // Zero span acts as a span of 1.0 and zero stripe count as one stripe.
        set_view(32'h0, 32'h0, 32'h0, MODE_RAMP16);
        send_sample(32'h0000_4000);
        send_sample(32'h0000_FFFF);
        set_view(32'h8000_0000, 32'hFFFF_FFFF, 32'd2047, MODE_RAINBOW);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0000);
        set_view(32'h7FFF_FFFF, 32'h0001_0000, 32'd1024, MODE_GREY);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        // Exactly half a level rounds up to white.
        set_view(32'h0, 32'h0001_0000, 32'd1, MODE_BINARY);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_7FFF);
        for (int m = MODE_BINARY + 1; m < 2 ** MODE_W; m++) begin
            set_view(32'h0, 32'h0001_0000, 32'd1, m);
            send_sample(32'h0000_4000);
        end
        set_view(32'h0, 32'h0001_0000, 32'd1, MODE_RAINBOW);
        send_sample(32'h0001_0000);
        send_sample(32'h0000_0000);
        send_sample(32'h0000_3333);
        send_sample(32'h0000_CCCD);
    endtask

    task automatic test_random_traffic(input int idle, input int stall);
        logic [31:0] vmin;
        logic [31:0] span;
        logic [31:0] stripes;
        logic [31:0] mode;
        int          pick;
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int v = 0; v < ITEMS_PER_PHASE / ITEMS_PER_VIEW; v++) begin
            case ($urandom_range(7))
                0:       vmin = 32'h0;
                1:       vmin = 32'h8000_0000;
                2:       vmin = 32'h7FFF_FFFF;
                default: vmin = $urandom;
            endcase
            case ($urandom_range(7))
                0:       span = 32'h0;
                1:       span = 32'hFFFF_FFFF;
                2:       span = $urandom;
                3:       span = $urandom_range(1, 64);
                default: span = $urandom_range(1, 32'h0004_0000);
            endcase
            case ($urandom_range(5))
                0:       stripes = 32'd0;
                1:       stripes = 32'd1;
                2:       stripes = 32'd1024;
                3:       stripes = 32'd2047;
                default: stripes = $urandom_range(1, 16);
            endcase
            pick = $urandom_range(11);
            mode = (pick < 10) ? pick % (MODE_BINARY + 1)
                               : $urandom_range(MODE_BINARY + 1, 2 ** MODE_W - 1);
            // Bits above each register's width are noise and must be dropped.
            stripes = ($urandom & ~32'(2 ** STRIPE_W - 1)) | stripes;
            mode    = ($urandom & ~32'(2 ** MODE_W - 1)) | mode;
            set_view(vmin, span, stripes, mode);
            for (int k = 0; k < ITEMS_PER_VIEW; k++) send_sample(pick_sample());
        end
    endtask

    always @(posedge i_clk) begin : pixel_check
        logic pixel_beat;
        pixel_beat = i_rst_n === 1'b1 && o_pixel_valid === 1'b1 && i_pixel_stall === 1'b0;
        if (pixel_beat) begin
            if (pending_pixels.size() == 0)
                note_mismatch("without a sample", 'x, o_pixel_word);
            else if (pending_pixels[0] !== o_pixel_word)
                note_mismatch("mismatch", pending_pixels.pop_front(), o_pixel_word);
            else
                void'(pending_pixels.pop_front());
        end
        if (pixel_beat || (i_sample_valid && o_sample_stall === 1'b0)
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_extremes();
        test_color_modes();
        test_random_traffic(0, 0);
        test_random_traffic(49, 0);
        test_random_traffic(0, 49);
        test_random_traffic(20, 20);
        wait_idle();
        repeat (PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
